>>> hdl/vaar_pkg.sv
package vaar_pkg;

  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES      = 24;

  // Field widths.
  localparam int unsigned VW  = 32;  // vector component, Q16.16
  localparam int unsigned AXW = 16;  // axis component, Q2.14
  localparam int unsigned OW  = 32;  // result component, Q16.16

  // Internal widths.
  localparam int unsigned CW  = 34;        // CORDIC x, y and residual angle
  localparam int unsigned SPW = CW + AXW;  // sin times axis
  localparam int unsigned QW  = 26;        // quaternion terms, Q.22
  localparam int unsigned PPW = QW + VW;   // first product terms
  localparam int unsigned PSW = PPW + 3;   // first product sums
  localparam int unsigned PW  = 40;        // first product, Q.18
  localparam int unsigned RPW = PW + QW;   // second product terms
  localparam int unsigned RSW = RPW + 3;   // second product sums
  localparam int unsigned RRW = RSW - 24;  // second product rounded to Q.16

  localparam int unsigned TAG_W = 3 * VW + 3 * AXW;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;

  // Arctangent of 2^-i, with one full turn as 2^32.
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic valid;
    logic upper;
  } cord_ctl_t;

endpackage

>>> hdl/vaar_cordic.sv
module vaar_cordic #(
  parameter int unsigned ANGLE_BITS    = vaar_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = vaar_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned TAG_W         = vaar_pkg::TAG_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [ANGLE_BITS-1:0]           angle_i,
  input  logic [TAG_W-1:0]                tag_i,
  output vaar_pkg::cord_ctl_t             ctl_o,
  output logic signed [vaar_pkg::CW-1:0]  x_o,
  output logic signed [vaar_pkg::CW-1:0]  y_o,
  output logic [TAG_W-1:0]                tag_o
);

  localparam int unsigned CW = vaar_pkg::CW;

  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_q [CORDIC_STAGES+1];
  logic [TAG_W-1:0]     tag_q [CORDIC_STAGES+1];
  logic                 up_q  [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] valid_q;

  logic [31:0] phase;
  logic        upper;
  logic [31:0] z_start;

  // The half angle as a 32 bit phase lies below a half turn.
  assign phase   = {1'b0, angle_i, {(31 - ANGLE_BITS){1'b0}}};
  assign upper   = (phase >= vaar_pkg::QUARTER_TURN);
  assign z_start = upper ? (phase - vaar_pkg::QUARTER_TURN) : phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[CORDIC_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CW'(vaar_pkg::CORDIC_GAIN_Q30);
    y_q[0]   <= '0;
    z_q[0]   <= CW'(z_start);
    up_q[0]  <= upper;
    tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] atan_c;
    assign atan_c = CW'(vaar_pkg::ATAN_TURNS[i]);

    always_ff @(posedge clk_i) begin
      if (!z_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_c;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_c;
      end
      up_q[i+1]  <= up_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  assign ctl_o.valid = valid_q[CORDIC_STAGES];
  assign ctl_o.upper = up_q[CORDIC_STAGES];
  assign x_o         = x_q[CORDIC_STAGES];
  assign y_o         = y_q[CORDIC_STAGES];
  assign tag_o       = tag_q[CORDIC_STAGES];

endmodule

>>> hdl/vaar_quat.sv
module vaar_quat (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vaar_pkg::cord_ctl_t              ctl_i,
  input  logic signed [vaar_pkg::CW-1:0]   x_i,
  input  logic signed [vaar_pkg::CW-1:0]   y_i,
  input  logic [vaar_pkg::TAG_W-1:0]       tag_i,
  output logic                             done_o,
  output logic signed [vaar_pkg::OW-1:0]   out_x_o,
  output logic signed [vaar_pkg::OW-1:0]   out_y_o,
  output logic signed [vaar_pkg::OW-1:0]   out_z_o,
  output logic                             clipped_o
);

  localparam int unsigned CW  = vaar_pkg::CW;
  localparam int unsigned VW  = vaar_pkg::VW;
  localparam int unsigned AXW = vaar_pkg::AXW;
  localparam int unsigned SPW = vaar_pkg::SPW;
  localparam int unsigned QW  = vaar_pkg::QW;
  localparam int unsigned PPW = vaar_pkg::PPW;
  localparam int unsigned PSW = vaar_pkg::PSW;
  localparam int unsigned PW  = vaar_pkg::PW;
  localparam int unsigned RPW = vaar_pkg::RPW;
  localparam int unsigned RSW = vaar_pkg::RSW;
  localparam int unsigned RRW = vaar_pkg::RRW;
  localparam int unsigned OW  = vaar_pkg::OW;

  localparam logic signed [RRW-1:0] OUT_MAX = RRW'({1'b0, {(OW-1){1'b1}}});
  localparam logic signed [RRW-1:0] OUT_MIN = ~OUT_MAX;

  logic [5:0] valid_q;

  // Stage 1: quadrant fix-up, cos rounding, sin times axis.
  logic signed [CW-1:0]  c_sel, s_sel, c_rnd;
  logic signed [AXW-1:0] ax [3];
  logic signed [VW-1:0]  vin [3];
  logic signed [SPW-1:0] sp_q [3];
  logic signed [QW-1:0]  qw1_q;
  logic signed [VW-1:0]  v1_q [3];

  // Stage 2.
  logic signed [QW-1:0]  qv2_q [3];
  logic signed [QW-1:0]  qw2_q;
  logic signed [VW-1:0]  v2_q [3];

  // Stage 3: first product terms.
  logic signed [PPW-1:0] ww_q [3];
  logic signed [PPW-1:0] vv_q [3][3];
  logic signed [QW-1:0]  qv3_q [3];
  logic signed [QW-1:0]  qw3_q;

  // Stage 4: first product sums.
  logic signed [PSW-1:0] pw_sum;
  logic signed [PSW-1:0] pv_sum [3];
  logic signed [PW-1:0]  pw4_q;
  logic signed [PW-1:0]  pv4_q [3];
  logic signed [QW-1:0]  qv4_q [3];
  logic signed [QW-1:0]  qw4_q;

  // Stage 5: second product terms.
  logic signed [RPW-1:0] a5_q [3];
  logic signed [RPW-1:0] b5_q [3];
  logic signed [RPW-1:0] c12_q, c21_q, c20_q, c02_q, c01_q, c10_q;

  // Stage 6: sums, rounding and saturation.
  logic signed [RSW-1:0] r_sum [3];
  logic signed [RRW-1:0] r_rnd [3];
  logic signed [OW-1:0]  out_d [3];
  logic [2:0]            clip_d;
  logic signed [OW-1:0]  out_q [3];
  logic                  clipped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[4:0], ctl_i.valid};
    end
  end

  assign vin[0] = tag_i[3*AXW + 3*VW - 1 : 3*AXW + 2*VW];
  assign vin[1] = tag_i[3*AXW + 2*VW - 1 : 3*AXW + VW];
  assign vin[2] = tag_i[3*AXW + VW - 1   : 3*AXW];
  assign ax[0]  = tag_i[3*AXW - 1 : 2*AXW];
  assign ax[1]  = tag_i[2*AXW - 1 : AXW];
  assign ax[2]  = tag_i[AXW - 1 : 0];

  always_comb begin
    c_sel = ctl_i.upper ? -y_i : x_i;
    s_sel = ctl_i.upper ? x_i : y_i;
    c_rnd = c_sel + CW'(128);
  end

  always_ff @(posedge clk_i) begin
    qw1_q <= c_rnd[QW+7:8];
    for (int k = 0; k < 3; k++) begin
      sp_q[k] <= SPW'(s_sel) * SPW'(ax[k]);
      v1_q[k] <= vin[k];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [SPW-1:0] t;
    qw2_q <= qw1_q;
    for (int k = 0; k < 3; k++) begin
      t        = sp_q[k] + SPW'(2**21);
      qv2_q[k] <= t[QW+21:22];
      v2_q[k]  <= v1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    qw3_q <= qw2_q;
    for (int i = 0; i < 3; i++) begin
      ww_q[i]  <= PPW'(qw2_q) * PPW'(v2_q[i]);
      qv3_q[i] <= qv2_q[i];
      for (int j = 0; j < 3; j++) begin
        vv_q[i][j] <= PPW'(qv2_q[i]) * PPW'(v2_q[j]);
      end
    end
  end

  always_comb begin
    pw_sum    = -(PSW'(vv_q[0][0]) + PSW'(vv_q[1][1]) + PSW'(vv_q[2][2])) + PSW'(2**19);
    pv_sum[0] = PSW'(ww_q[0]) + PSW'(vv_q[1][2]) - PSW'(vv_q[2][1]) + PSW'(2**19);
    pv_sum[1] = PSW'(ww_q[1]) + PSW'(vv_q[2][0]) - PSW'(vv_q[0][2]) + PSW'(2**19);
    pv_sum[2] = PSW'(ww_q[2]) + PSW'(vv_q[0][1]) - PSW'(vv_q[1][0]) + PSW'(2**19);
  end

  always_ff @(posedge clk_i) begin
    pw4_q <= pw_sum[PW+19:20];
    qw4_q <= qw3_q;
    for (int k = 0; k < 3; k++) begin
      pv4_q[k] <= pv_sum[k][PW+19:20];
      qv4_q[k] <= qv3_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a5_q[k] <= RPW'(pw4_q) * RPW'(qv4_q[k]);
      b5_q[k] <= RPW'(qw4_q) * RPW'(pv4_q[k]);
    end
    c12_q <= RPW'(pv4_q[1]) * RPW'(qv4_q[2]);
    c21_q <= RPW'(pv4_q[2]) * RPW'(qv4_q[1]);
    c20_q <= RPW'(pv4_q[2]) * RPW'(qv4_q[0]);
    c02_q <= RPW'(pv4_q[0]) * RPW'(qv4_q[2]);
    c01_q <= RPW'(pv4_q[0]) * RPW'(qv4_q[1]);
    c10_q <= RPW'(pv4_q[1]) * RPW'(qv4_q[0]);
  end

  always_comb begin
    r_sum[0] = -RSW'(a5_q[0]) + RSW'(b5_q[0]) - RSW'(c12_q) + RSW'(c21_q) + RSW'(2**23);
    r_sum[1] = -RSW'(a5_q[1]) + RSW'(b5_q[1]) - RSW'(c20_q) + RSW'(c02_q) + RSW'(2**23);
    r_sum[2] = -RSW'(a5_q[2]) + RSW'(b5_q[2]) - RSW'(c01_q) + RSW'(c10_q) + RSW'(2**23);
    for (int k = 0; k < 3; k++) begin
      r_rnd[k] = r_sum[k][RSW-1:24];
      if (r_rnd[k] > OUT_MAX) begin
        out_d[k]  = OW'(OUT_MAX);
        clip_d[k] = 1'b1;
      end else if (r_rnd[k] < OUT_MIN) begin
        out_d[k]  = OW'(OUT_MIN);
        clip_d[k] = 1'b1;
      end else begin
        out_d[k]  = r_rnd[k][OW-1:0];
        clip_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      out_q[k] <= out_d[k];
    end
    clipped_q <= |clip_d;
  end

  assign done_o    = valid_q[5];
  assign out_x_o   = out_q[0];
  assign out_y_o   = out_q[1];
  assign out_z_o   = out_q[2];
  assign clipped_o = clipped_q;

endmodule

>>> hdl/vector_axis_angle_rotate.sv
// Rotates a Q16.16 vector about a Q2.14 axis by a binary angle, using the
// quaternion q = (sin(a/2)*axis, cos(a/2)) and the product q*(v,0)*conj(q).
// Requests enter on start with the vector, axis and angle on their own ports.
// A request is taken at every rising edge where start is high and busy is
// low; busy is never raised, so one request can be taken in every cycle.
// Each result stays for exactly one cycle, marked by done_o. Results leave
// in request order, one per request. The datapath is the sine and cosine
// pipeline, an input register and one register per CORDIC stage, followed
// by six stages of products, sums and saturation.
// The receiver cannot stall the block and must take each result when done_o
// is high. clipped_o is set when any component saturated.
// Reset clears all valid bits, so no result appears for requests that were
// in flight when reset was applied.
module vector_axis_angle_rotate #(
  parameter int unsigned ANGLE_BITS    = vaar_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = vaar_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [vaar_pkg::VW-1:0]  vec_x_i,
  input  logic signed [vaar_pkg::VW-1:0]  vec_y_i,
  input  logic signed [vaar_pkg::VW-1:0]  vec_z_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_x_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_y_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_z_i,
  input  logic [ANGLE_BITS-1:0]           turn_angle_i,
  output logic                           done_o,
  output logic signed [vaar_pkg::OW-1:0]  out_x_o,
  output logic signed [vaar_pkg::OW-1:0]  out_y_o,
  output logic signed [vaar_pkg::OW-1:0]  out_z_o,
  output logic                           clipped_o
);

  logic [vaar_pkg::TAG_W-1:0]     tag_in, tag_out;
  vaar_pkg::cord_ctl_t            cord_ctl;
  logic signed [vaar_pkg::CW-1:0] cord_x, cord_y;

  assign busy   = 1'b0;
  assign tag_in = {vec_x_i, vec_y_i, vec_z_i, axis_x_i, axis_y_i, axis_z_i};

  vaar_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .TAG_W         (vaar_pkg::TAG_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .angle_i (turn_angle_i),
    .tag_i   (tag_in),
    .ctl_o   (cord_ctl),
    .x_o     (cord_x),
    .y_o     (cord_y),
    .tag_o   (tag_out)
  );

  vaar_quat u_quat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cord_ctl),
    .x_i       (cord_x),
    .y_i       (cord_y),
    .tag_i     (tag_out),
    .done_o    (done_o),
    .out_x_o   (out_x_o),
    .out_y_o   (out_y_o),
    .out_z_o   (out_z_o),
    .clipped_o (clipped_o)
  );

endmodule

>>> hdl/vaar_checker.sv
module vaar_checker #(
  parameter int unsigned CORDIC_STAGES = vaar_pkg::CORDIC_STAGES_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // Distance from a taken request to the sampled done_o strobe.
  localparam int unsigned LAT = CORDIC_STAGES + 7;

  // The pipeline never holds requests off.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every request taken yields a result after the fixed latency.
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after request");

  // No result appears without a request the fixed latency before.
  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without request");

endmodule

bind vector_axis_angle_rotate vaar_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_vaar_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

>>> test/vaar_checker.sv
`timescale 1ns / 1ps

module vaar_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [vaar_pkg::VW-1:0]  vec_x_i,
  input  logic signed [vaar_pkg::VW-1:0]  vec_y_i,
  input  logic signed [vaar_pkg::VW-1:0]  vec_z_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_x_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_y_i,
  input  logic signed [vaar_pkg::AXW-1:0] axis_z_i,
  input  logic [15:0]                     turn_angle_i,
  input  logic                            done_o,
  input  logic signed [vaar_pkg::OW-1:0]  out_x_o,
  input  logic signed [vaar_pkg::OW-1:0]  out_y_o,
  input  logic signed [vaar_pkg::OW-1:0]  out_z_o,
  input  logic                            clipped_o,
  output int                              fails,
  output int                              pending
);

  typedef struct {
    logic signed [vaar_pkg::OW-1:0] x;
    logic signed [vaar_pkg::OW-1:0] y;
    logic signed [vaar_pkg::OW-1:0] z;
    logic                           clip;
  } rotated_t;

  rotated_t rotated_q[$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(longint v, ref logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic rotated_t rotate_vector(longint v[3], longint ax[3], logic [15:0] ang);
    rotated_t res;
    longint phase, z, cx, sy, dx, dy, c, s, qw, pw;
    longint qv[3], pv[3], rv[3];
    logic upper, clip;
    phase = longint'(ang) << 15;
    upper = phase >= longint'(vaar_pkg::QUARTER_TURN);
    z = upper ? phase - longint'(vaar_pkg::QUARTER_TURN) : phase;
    cx = longint'(vaar_pkg::CORDIC_GAIN_Q30);
    sy = 0;
    for (int i = 0; i < vaar_pkg::CORDIC_STAGES_DEF; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= longint'(vaar_pkg::ATAN_TURNS[i]);
      end else begin
        cx += dx; sy -= dy; z += longint'(vaar_pkg::ATAN_TURNS[i]);
      end
    end
    c = upper ? -sy : cx;
    s = upper ? cx : sy;
    qw = rnd_shift(c, 8);
    for (int k = 0; k < 3; k++) qv[k] = rnd_shift(s * ax[k], 22);
    pw    = rnd_shift(-(qv[0] * v[0] + qv[1] * v[1] + qv[2] * v[2]), 20);
    pv[0] = rnd_shift(qw * v[0] + qv[1] * v[2] - qv[2] * v[1], 20);
    pv[1] = rnd_shift(qw * v[1] + qv[2] * v[0] - qv[0] * v[2], 20);
    pv[2] = rnd_shift(qw * v[2] + qv[0] * v[1] - qv[1] * v[0], 20);
    rv[0] = -pw * qv[0] + qw * pv[0] - (pv[1] * qv[2] - pv[2] * qv[1]);
    rv[1] = -pw * qv[1] + qw * pv[1] - (pv[2] * qv[0] - pv[0] * qv[2]);
    rv[2] = -pw * qv[2] + qw * pv[2] - (pv[0] * qv[1] - pv[1] * qv[0]);
    clip = 1'b0;
    res.x = vaar_pkg::OW'(saturate(rnd_shift(rv[0], 24), clip));
    res.y = vaar_pkg::OW'(saturate(rnd_shift(rv[1], 24), clip));
    res.z = vaar_pkg::OW'(saturate(rnd_shift(rv[2], 24), clip));
    res.clip = clip;
    return res;
  endfunction

  assign pending = rotated_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint v[3], ax[3];
    rotated_t exp_r;
    if (!rst_ni) begin
      fails <= 0;
    end else begin
      if (start && !busy) begin
        v  = '{longint'(vec_x_i), longint'(vec_y_i), longint'(vec_z_i)};
        ax = '{longint'(axis_x_i), longint'(axis_y_i), longint'(axis_z_i)};
        rotated_q.push_back(rotate_vector(v, ax, turn_angle_i));
      end
      if (done_o) begin
        if (rotated_q.size() == 0) begin
          if (fails < 10) $display("result with no request outstanding at %0t", $realtime);
          fails <= fails + 1;
        end else begin
          exp_r = rotated_q.pop_front();
          if (exp_r.x !== out_x_o || exp_r.y !== out_y_o || exp_r.z !== out_z_o
              || exp_r.clip !== clipped_o) begin
            if (fails < 10)
              $display("mismatch at %0t: expected %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                       $realtime, exp_r.x, exp_r.y, exp_r.z, exp_r.clip,
                       out_x_o, out_y_o, out_z_o, clipped_o);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_RANDOM = 1700;
  localparam int CALM_TAIL  = 200;
  localparam int WATCHDOG   = 2000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic signed [vaar_pkg::VW-1:0]  vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [vaar_pkg::AXW-1:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic [15:0]                     turn_angle_i = '0;
  logic                            done_o, clipped_o;
  logic signed [vaar_pkg::OW-1:0]  out_x_o, out_y_o, out_z_o;
  int                              fails, pending;
  int                              quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vector_axis_angle_rotate DUT (.*);
  vaar_scoreboard u_checker (.*);

  // A request held on start counts as progress only when it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_request(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              logic [15:0] ang);
    vec_x_i <= vx; vec_y_i <= vy; vec_z_i <= vz;
    axis_x_i <= ax; axis_y_i <= ay; axis_z_i <= az;
    turn_angle_i <= ang;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_comp();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      1: return $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corners: zero and extreme vectors, cardinal angles, unit and oversized axes.
    send_request(0, 0, 0, 16'sd16384, 0, 0, 16'd0);
    send_request(32'sd65536, 0, 0, 0, 0, 16'sd16384, 16'd16384);
    send_request(32'sd65536, 32'sd65536, 0, 0, 0, 16'sd16384, 16'd32768);
    send_request(32'sd65536, 0, 32'sd65536, 0, 16'sd16384, 0, 16'd49152);
    send_request(32'sd65536, 32'sd131072, -32'sd65536, 16'sd16384, 0, 0, 16'd65535);
    send_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 16'sd16384, 16'd8192);
    send_request(32'h80000000, 32'h80000000, 32'h80000000, 16'sd16384, 0, 0, 16'd24576);
    send_request(32'h7fffffff, 32'h80000000, 0, 16'sd9459, 16'sd9459, 16'sd9459, 16'd21845);
    send_request(32'sd65536, 32'sd65536, 32'sd65536, 16'h7fff, 16'h7fff, 16'h7fff, 16'd16384);
    send_request(32'sd65536, -32'sd65536, 32'sd65536, 16'h8000, 16'h8000, 16'h8000, 16'd40000);
    send_request(32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 16'h7fff, 16'd12000);
    send_request(32'h12345678, -32'sd1, 32'sd1, 16'sd16384, 0, 0, 16'd16383);
    send_request(32'sd1, 32'sd1, 32'sd1, 0, 0, 0, 16'd1);
    send_request(32'h40000000, 32'h40000000, 0, 0, 0, 16'sd16384, 16'd32767);
    send_request(32'hfffe0000, 32'h00020000, 32'h7fff0000, 0, 16'sd8192, 0, 16'd65534);
    send_request(32'sd1000000, 32'sd2000000, 32'sd3000000, 16'sd16384, 16'sd16384, 0, 16'd49151);
    pause_sender();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_request(rand_comp(), rand_comp(), rand_comp(),
                   rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
      if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 5) == 0) pause_sender();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
